[src/assert_macros.svh]
// Assertion macros shared by the Hill cipher RTL.
// Self-contained; each macro has an empty form when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property check, disabled while reset is asserted.
`define HC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hill cipher property violated");
// Condition that must never be true at a clock edge outside reset.
`define HC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hill cipher forbidden condition seen");
`else
`define HC_ASSERT(label, clk, rst_n, prop)
`define HC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[src/hc22_pkg.sv]
// Shared types and constants for the 2x2 Hill cipher block.
// No dependencies; imported by the controller, datapath and top level.
package hc22_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_KEY_A   = 3'd0;
    localparam t_cfg_idx CFG_KEY_B   = 3'd1;
    localparam t_cfg_idx CFG_KEY_C   = 3'd2;
    localparam t_cfg_idx CFG_KEY_D   = 3'd3;
    localparam t_cfg_idx CFG_DECRYPT = 3'd4;

    // Index of the last Newton step for an 8-bit odd inverse.
    localparam logic [1:0] NEWTON_LAST = 2'd2;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture_in;
        logic load_det;
        logic newton_t;
        logic newton_y;
        logic load_inv;
        logic hold_byte;
        logic calc_pair;
        logic use_held;
        logic set_invalid;
        logic show_second;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic decrypt_mode;
        logic det_odd;
        logic in_last;
        logic cfg_write;
    } t_dp_status;

endpackage

[src/hc22_datapath.sv]
// Datapath of the 2x2 Hill cipher: key registers, inverse-key unit and pair multiplier.
// Depends on hc22_pkg; driven by commands from hc22_ctrl.
module hc22_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  hc22_pkg::t_cfg_idx  i_cfg_index,
    input  hc22_pkg::t_byte     i_cfg_data,
    input  hc22_pkg::t_byte     i_data_byte,
    input  logic                i_last,
    input  hc22_pkg::t_dp_cmd   i_cmd,
    output hc22_pkg::t_dp_status o_status,
    output hc22_pkg::t_byte     o_out_byte,
    output logic                o_out_last,
    output logic                o_key_invalid
);
    import hc22_pkg::*;

    t_byte r_key_a, r_key_b, r_key_c, r_key_d;
    logic  r_decrypt;
    t_byte r_inv [4];
    t_byte r_det, r_y, r_t;
    t_byte r_in_byte;
    logic  r_in_last;
    t_byte r_held;
    t_byte r_res0, r_res1;
    logic  r_res_last, r_res_inv;

    logic [15:0] w_ad, w_bc, w_xy, w_yt;
    logic [15:0] w_i0, w_i1, w_i2, w_i3;
    logic [15:0] w_p00, w_p01, w_p10, w_p11;
    t_byte       w_m0, w_m1, w_m2, w_m3, w_p0, w_p1;
    t_byte       w_neg_b, w_neg_c;
    logic        w_cfg_hit;

    assign w_cfg_hit = i_cfg_we && (i_cfg_index <= CFG_DECRYPT);

    // Determinant and Newton step products.
    assign w_ad = 16'(r_key_a) * 16'(r_key_d);
    assign w_bc = 16'(r_key_b) * 16'(r_key_c);
    assign w_xy = 16'(r_det) * 16'(r_y);
    assign w_yt = 16'(r_y) * 16'(r_t);

    // Adjugate times the inverse determinant.
    assign w_neg_b = 8'd0 - r_key_b;
    assign w_neg_c = 8'd0 - r_key_c;
    assign w_i0 = 16'(r_key_d) * 16'(r_y);
    assign w_i1 = 16'(w_neg_b) * 16'(r_y);
    assign w_i2 = 16'(w_neg_c) * 16'(r_y);
    assign w_i3 = 16'(r_key_a) * 16'(r_y);

    // Pair transform.
    assign w_m0 = r_decrypt ? r_inv[0] : r_key_a;
    assign w_m1 = r_decrypt ? r_inv[1] : r_key_b;
    assign w_m2 = r_decrypt ? r_inv[2] : r_key_c;
    assign w_m3 = r_decrypt ? r_inv[3] : r_key_d;
    assign w_p0 = i_cmd.use_held ? r_held : r_in_byte;
    assign w_p1 = i_cmd.use_held ? r_in_byte : 8'd0;
    assign w_p00 = 16'(w_m0) * 16'(w_p0);
    assign w_p01 = 16'(w_m1) * 16'(w_p1);
    assign w_p10 = 16'(w_m2) * 16'(w_p0);
    assign w_p11 = 16'(w_m3) * 16'(w_p1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a   <= 8'd1;
            r_key_b   <= 8'd0;
            r_key_c   <= 8'd0;
            r_key_d   <= 8'd1;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_A:   r_key_a   <= i_cfg_data;
                CFG_KEY_B:   r_key_b   <= i_cfg_data;
                CFG_KEY_C:   r_key_c   <= i_cfg_data;
                CFG_KEY_D:   r_key_d   <= i_cfg_data;
                CFG_DECRYPT: r_decrypt <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_in) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
        if (i_cmd.load_det) begin
            r_det <= w_ad[7:0] - w_bc[7:0];
            r_y   <= w_ad[7:0] - w_bc[7:0];
        end
        if (i_cmd.newton_t) begin
            r_t <= 8'd2 - w_xy[7:0];
        end
        if (i_cmd.newton_y) begin
            r_y <= w_yt[7:0];
        end
        if (i_cmd.load_inv) begin
            // An even determinant leaves an all-zero inverse.
            r_inv[0] <= r_det[0] ? w_i0[7:0] : 8'd0;
            r_inv[1] <= r_det[0] ? w_i1[7:0] : 8'd0;
            r_inv[2] <= r_det[0] ? w_i2[7:0] : 8'd0;
            r_inv[3] <= r_det[0] ? w_i3[7:0] : 8'd0;
        end
        if (i_cmd.hold_byte) begin
            r_held <= r_in_byte;
        end
        if (i_cmd.calc_pair) begin
            r_res0     <= w_p00[7:0] + w_p01[7:0];
            r_res1     <= w_p10[7:0] + w_p11[7:0];
            r_res_last <= r_in_last;
            r_res_inv  <= 1'b0;
        end else if (i_cmd.set_invalid) begin
            r_res1     <= 8'd0;
            r_res_last <= 1'b1;
            r_res_inv  <= 1'b1;
        end
    end

    assign o_status.decrypt_mode = r_decrypt;
    assign o_status.det_odd      = r_det[0];
    assign o_status.in_last      = r_in_last;
    assign o_status.cfg_write    = w_cfg_hit;

    assign o_out_byte    = i_cmd.show_second ? r_res1 : r_res0;
    assign o_out_last    = i_cmd.show_second & r_res_last;
    assign o_key_invalid = i_cmd.show_second & r_res_inv;

endmodule

[src/hc22_ctrl.sv]
// Controller state machine of the 2x2 Hill cipher: sequencing, pairing and stream state.
// Depends on hc22_pkg and assert_macros.svh; commands hc22_datapath.
`include "assert_macros.svh"
module hc22_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  hc22_pkg::t_dp_status i_status,
    output hc22_pkg::t_dp_cmd    o_cmd
);
    import hc22_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DET  = 8'b0000_0010,
        S_NT   = 8'b0000_0100,
        S_NY   = 8'b0000_1000,
        S_INV  = 8'b0001_0000,
        S_EVAL = 8'b0010_0000,
        S_OUT0 = 8'b0100_0000,
        S_OUT1 = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_iter, n_iter;
    logic       r_have_held, n_have_held;
    logic       r_inverse_ready, n_inverse_ready;
    logic       r_inverse_ok, n_inverse_ok;

    always_comb begin
        n_state         = r_state;
        n_iter          = r_iter;
        n_have_held     = r_have_held;
        n_inverse_ready = r_inverse_ready;
        n_inverse_ok    = r_inverse_ok;
        o_cmd           = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture_in = 1'b1;
                    if (i_status.decrypt_mode && !r_inverse_ready) begin
                        n_state = S_DET;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_DET: begin
                o_cmd.load_det = 1'b1;
                n_iter         = 2'd0;
                n_state        = S_NT;
            end
            S_NT: begin
                o_cmd.newton_t = 1'b1;
                n_state        = S_NY;
            end
            S_NY: begin
                o_cmd.newton_y = 1'b1;
                if (r_iter == NEWTON_LAST) begin
                    n_state = S_INV;
                end else begin
                    n_iter  = r_iter + 2'd1;
                    n_state = S_NT;
                end
            end
            S_INV: begin
                o_cmd.load_inv  = 1'b1;
                n_inverse_ready = 1'b1;
                n_inverse_ok    = i_status.det_odd;
                n_state         = S_EVAL;
            end
            S_EVAL: begin
                if (i_status.decrypt_mode && !r_inverse_ok) begin
                    // Key cannot be inverted: drop the data, flag the end of the stream.
                    n_have_held = 1'b0;
                    if (i_status.in_last) begin
                        o_cmd.set_invalid = 1'b1;
                        n_inverse_ready   = 1'b0;
                        n_state           = S_OUT1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (!r_have_held && !i_status.in_last) begin
                    o_cmd.hold_byte = 1'b1;
                    n_have_held     = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.calc_pair = 1'b1;
                    o_cmd.use_held  = r_have_held;
                    n_have_held     = 1'b0;
                    if (i_status.in_last) begin
                        n_inverse_ready = 1'b0;
                    end
                    n_state = S_OUT0;
                end
            end
            S_OUT0: begin
                if (i_out_ready) begin
                    n_state = S_OUT1;
                end
            end
            S_OUT1: begin
                o_cmd.show_second = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // A register write always makes the inverse stale.
        if (i_status.cfg_write) begin
            n_inverse_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_iter          <= 2'd0;
            r_have_held     <= 1'b0;
            r_inverse_ready <= 1'b0;
            r_inverse_ok    <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_iter          <= n_iter;
            r_have_held     <= n_have_held;
            r_inverse_ready <= n_inverse_ready;
            r_inverse_ok    <= n_inverse_ok;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT0) || (r_state == S_OUT1);

    `HC_ASSERT(a_inv_sets_ready, i_clk, i_rst_n, (r_state == S_INV && !i_status.cfg_write) |=> r_inverse_ready)
    `HC_ASSERT(a_cfg_clears_ready, i_clk, i_rst_n, i_status.cfg_write |=> !r_inverse_ready)
    `HC_ASSERT_NEVER(a_pair_leaves_held, i_clk, i_rst_n, (r_state == S_OUT0) && r_have_held)
    `HC_ASSERT_NEVER(a_ready_while_valid, i_clk, i_rst_n, o_in_ready && o_out_valid)

endmodule

[src/hill_cipher_2x2_mod256_core.sv]
// Top level of the 2x2 Hill cipher over bytes mod 256.
// Depends on hc22_pkg, hc22_ctrl and hc22_datapath.
//
// Usage: bytes enter one per request on the input channel (i_in_valid/o_in_ready,
// with i_data_byte and i_last). The first byte of a pair is held; the second
// produces two result requests on the output channel (o_out_valid/i_out_ready):
// the key matrix, or its inverse in decrypt mode, times the pair, mod 256.
// A last byte with no partner is paired with a zero byte. With an even
// determinant in decrypt mode data is dropped and the last byte yields one
// result with o_key_invalid set.
// Sequencing: a held byte passes through the evaluation state back to idle. A
// pair-completing byte is accepted, the products are registered in the
// evaluation state, and its two results follow in the output states, one after
// the other, when the receiver is ready. The controller handles one byte at a
// time and the input is not ready while a result waits. In decrypt mode the
// first byte of each stream first waits for the inverse: the determinant, three
// Newton steps on its odd inverse, then the adjugate products.
// A stalled receiver simply holds the present result until it is taken.
// Reset restores the identity key, encrypt mode and an empty pair holder.
// Configuration writes take effect at once and must be made while idle.
module hill_cipher_2x2_mod256_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hc22_pkg::t_byte    i_data_byte,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hc22_pkg::t_byte    o_out_byte,
    output logic               o_out_last,
    output logic               o_key_invalid,
    input  logic               i_cfg_we,
    input  hc22_pkg::t_cfg_idx i_cfg_index,
    input  hc22_pkg::t_byte    i_cfg_data
);
    import hc22_pkg::*;

    // Command and status buses between the controller and the datapath.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    hc22_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    hc22_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_key_invalid (o_key_invalid)
    );

endmodule
